@@ hdl/tvp_pkg.sv @@
package tvp_pkg;

    // Field and register widths
    localparam int TIME_WIDTH = 20;
    localparam int TRAV_W     = 20;
    localparam int COOL_W     = 16;
    localparam int POS_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Shared divider: dividend holds a time value scaled by 255 or a travel value scaled by the position delta
    localparam int DIV_W      = (TIME_WIDTH > TRAV_W) ? TIME_WIDTH + POS_W : TRAV_W + POS_W;
    localparam int DIV_STEPS  = (DIV_W + 1) / 2;
    localparam int DIV_PAD_W  = 2 * DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [TIME_WIDTH-1:0] TIME_MAX   = '1;
    localparam logic [TRAV_W-1:0]     FULL_SCALE = TRAV_W'((1 << POS_W) - 1);

    // Register reset values
    localparam logic [TRAV_W-1:0] OPEN_TRAVEL_RST  = TRAV_W'(10000);
    localparam logic [TRAV_W-1:0] CLOSE_TRAVEL_RST = TRAV_W'(10000);
    localparam logic [COOL_W-1:0] COOLDOWN_RST     = COOL_W'(1000);
    localparam logic [POS_W-1:0]  TOLERANCE_RST    = '0;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_OPENING  = 2'd1,
        MODE_CLOSING  = 2'd2,
        MODE_COOLDOWN = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OPEN_TRAVEL  = 2'd0,
        REG_CLOSE_TRAVEL = 2'd1,
        REG_COOLDOWN     = 2'd2,
        REG_TOLERANCE    = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        DOP_DUR = 2'd0,   // |delta| * travel / 255
        DOP_A   = 2'd1,   // elapsed * 255 / travel
        DOP_B   = 2'd2    // move_time * 255 / travel
    } t_div_op;

    typedef struct packed {
        logic    load_target;
        logic    div_start;
        t_div_op div_op;
        logic    cap_a;
        logic    commit;
    } t_dp_cmd;

    typedef struct packed {
        logic start_move;
        logic need_est;
        logic div_done;
    } t_dp_status;

endpackage

@@ hdl/tvp_div.sv @@
module tvp_div
    import tvp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [TRAV_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIV_W-1:0]  o_quotient
);

    // Restoring divider, two quotient bits per cycle
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [TRAV_W-1:0]    r_rem;
    logic [TRAV_W-1:0]    r_div;
    logic [DIV_PAD_W-1:0] r_quo;

    logic [TRAV_W:0]      rem1;
    logic [TRAV_W:0]      rem2;
    logic                 ge1;
    logic                 ge2;
    logic [TRAV_W-1:0]    rem1r;
    logic [TRAV_W-1:0]    n_rem;
    logic [DIV_PAD_W-1:0] quo1;
    logic [DIV_PAD_W-1:0] n_quo;

    always_comb begin
        rem1  = {r_rem, r_quo[DIV_PAD_W-1]};
        ge1   = rem1 >= {1'b0, r_div};
        rem1r = ge1 ? TRAV_W'(rem1 - {1'b0, r_div}) : rem1[TRAV_W-1:0];
        quo1  = {r_quo[DIV_PAD_W-2:0], ge1};
        rem2  = {rem1r, quo1[DIV_PAD_W-1]};
        ge2   = rem2 >= {1'b0, r_div};
        n_rem = ge2 ? TRAV_W'(rem2 - {1'b0, r_div}) : rem2[TRAV_W-1:0];
        n_quo = {quo1[DIV_PAD_W-2:0], ge2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= DIV_PAD_W'(i_dividend);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[DIV_W-1:0];

endmodule

@@ hdl/tvp_datapath.sv @@
module tvp_datapath
    import tvp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [POS_W-1:0]      i_target_open,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output logic                  o_open_drive,
    output logic                  o_close_drive,
    output logic [POS_W-1:0]      o_position_estimate,
    output logic [1:0]            o_mode_now
);

    // Configuration registers
    logic [TRAV_W-1:0] r_open_travel;
    logic [TRAV_W-1:0] r_close_travel;
    logic [COOL_W-1:0] r_cooldown_ms;
    logic [POS_W-1:0]  r_tolerance;

    // Block state
    t_mode                 r_mode;
    logic [POS_W-1:0]      r_position;
    logic [TIME_WIDTH-1:0] r_move_time;
    logic [TIME_WIDTH-1:0] r_elapsed;
    logic [COOL_W-1:0]     r_cool_left;

    // Working registers
    logic [POS_W-1:0] r_target;
    logic [POS_W-1:0] r_qa;

    // Result registers
    t_mode            r_o_mode;
    logic [POS_W-1:0] r_o_position;

    t_mode                 n_mode;
    logic [POS_W-1:0]      n_position;
    logic [TIME_WIDTH-1:0] n_move_time;
    logic [TIME_WIDTH-1:0] n_elapsed;
    logic [COOL_W-1:0]     n_cool_left;

    logic [POS_W:0]              delta;
    logic                        delta_neg;
    logic [POS_W-1:0]            mag;
    logic                        dir_open;
    logic                        opening;
    logic                        moving;
    logic                        stop_move;
    logic                        reached;
    logic [TIME_WIDTH-1:0]       e_inc;
    logic [TRAV_W-1:0]           travel_dir;
    logic [TRAV_W-1:0]           travel_mov;
    logic [TRAV_W-1:0]           travel_nz;
    logic [TRAV_W+POS_W-1:0]     prod_dur;
    logic [TIME_WIDTH+POS_W-1:0] e_scaled;
    logic [TIME_WIDTH+POS_W-1:0] m_scaled;
    logic [DIV_W-1:0]            dividend;
    logic [TRAV_W-1:0]           divisor;
    logic [DIV_W-1:0]            quotient;
    logic                        div_done;
    logic [TIME_WIDTH-1:0]       dur_sat;
    logic [COOL_W-1:0]           cool_dec;
    logic [POS_W-1:0]            qb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_travel  <= OPEN_TRAVEL_RST;
            r_close_travel <= CLOSE_TRAVEL_RST;
            r_cooldown_ms  <= COOLDOWN_RST;
            r_tolerance    <= TOLERANCE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_OPEN_TRAVEL:  r_open_travel  <= i_cfg_data[TRAV_W-1:0];
                REG_CLOSE_TRAVEL: r_close_travel <= i_cfg_data[TRAV_W-1:0];
                REG_COOLDOWN:     r_cooldown_ms  <= i_cfg_data[COOL_W-1:0];
                REG_TOLERANCE:    r_tolerance    <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // Decision terms
    always_comb begin
        delta      = {1'b0, r_target} - {1'b0, r_position};
        delta_neg  = delta[POS_W];
        mag        = delta_neg ? POS_W'(-delta) : delta[POS_W-1:0];
        dir_open   = !delta_neg && (mag != '0);
        opening    = (r_mode == MODE_OPENING);
        moving     = opening || (r_mode == MODE_CLOSING);
        stop_move  = (mag <= r_tolerance) || (opening ? delta_neg : !delta_neg);
        e_inc      = (r_elapsed == TIME_MAX) ? r_elapsed : r_elapsed + 1'b1;
        reached    = e_inc >= r_move_time;
        travel_dir = dir_open ? r_open_travel : r_close_travel;
        travel_mov = opening ? r_open_travel : r_close_travel;
        travel_nz  = (travel_mov == '0) ? TRAV_W'(1) : travel_mov;
    end

    assign o_status.start_move = (r_mode == MODE_IDLE) && (r_cool_left == '0)
                                 && (mag > r_tolerance);
    assign o_status.need_est   = moving && !stop_move && !reached;
    assign o_status.div_done   = div_done;

    // Divider operands; x*255 as (x << 8) - x
    always_comb begin
        prod_dur = {{TRAV_W{1'b0}}, mag} * {{POS_W{1'b0}}, travel_dir};
        e_scaled = {e_inc, {POS_W{1'b0}}} - {{POS_W{1'b0}}, e_inc};
        m_scaled = {r_move_time, {POS_W{1'b0}}} - {{POS_W{1'b0}}, r_move_time};
        case (i_cmd.div_op)
            DOP_DUR: dividend = DIV_W'(prod_dur);
            DOP_A:   dividend = DIV_W'(e_scaled);
            DOP_B:   dividend = DIV_W'(m_scaled);
            default: dividend = '0;
        endcase
        divisor = (i_cmd.div_op == DOP_DUR) ? FULL_SCALE : travel_nz;
    end

    tvp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign dur_sat = (quotient > DIV_W'(TIME_MAX)) ? TIME_MAX : quotient[TIME_WIDTH-1:0];
    assign qb      = quotient[POS_W-1:0];
    assign cool_dec = (r_cool_left == '0) ? r_cool_left : r_cool_left - 1'b1;

    // Next state for the tick being finished
    always_comb begin
        n_mode      = r_mode;
        n_position  = r_position;
        n_move_time = r_move_time;
        n_elapsed   = r_elapsed;
        n_cool_left = r_cool_left;
        unique case (r_mode)
            MODE_IDLE: begin
                if (o_status.start_move) begin
                    n_move_time = dur_sat;
                    n_elapsed   = '0;
                    n_mode      = dir_open ? MODE_OPENING : MODE_CLOSING;
                end
            end
            MODE_OPENING, MODE_CLOSING: begin
                if (stop_move) begin
                    n_cool_left = r_cooldown_ms;
                    n_mode      = MODE_COOLDOWN;
                end else begin
                    n_elapsed = e_inc;
                    if (reached) begin
                        n_position  = r_target;
                        n_cool_left = r_cooldown_ms;
                        n_mode      = MODE_COOLDOWN;
                    end else if (opening) begin
                        n_position = r_qa + r_target - qb;
                    end else begin
                        n_position = r_target + qb - r_qa;
                    end
                end
            end
            MODE_COOLDOWN: begin
                n_cool_left = cool_dec;
                if (cool_dec == '0) begin
                    n_mode = MODE_IDLE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_position  <= '0;
            r_move_time <= '0;
            r_elapsed   <= '0;
            r_cool_left <= '0;
        end else if (i_cmd.commit) begin
            r_mode      <= n_mode;
            r_position  <= n_position;
            r_move_time <= n_move_time;
            r_elapsed   <= n_elapsed;
            r_cool_left <= n_cool_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_target) begin
            r_target <= i_target_open;
        end
        if (i_cmd.cap_a) begin
            r_qa <= quotient[POS_W-1:0];
        end
        if (i_cmd.commit) begin
            r_o_mode     <= n_mode;
            r_o_position <= n_position;
        end
    end

    assign o_open_drive        = (r_o_mode == MODE_OPENING);
    assign o_close_drive       = (r_o_mode == MODE_CLOSING);
    assign o_position_estimate = r_o_position;
    assign o_mode_now          = r_o_mode;

endmodule

@@ hdl/tvp_ctrl.sv @@
module tvp_ctrl
    import tvp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV_DUR,
        S_DIV_A,
        S_DIV_B,
        S_PUSH
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd             = '0;
        o_cmd.div_op      = DOP_DUR;
        o_cmd.load_target = (r_state == S_IDLE) && i_in_valid;
        unique case (r_state)
            S_EVAL: begin
                if (i_status.start_move) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op    = DOP_DUR;
                end else if (i_status.need_est) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op    = DOP_A;
                end
            end
            S_DIV_A: begin
                o_cmd.cap_a     = i_status.div_done;
                o_cmd.div_start = i_status.div_done;
                o_cmd.div_op    = DOP_B;
            end
            S_PUSH:  o_cmd.commit = slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (i_status.start_move) begin
                        r_state <= S_DIV_DUR;
                    end else if (i_status.need_est) begin
                        r_state <= S_DIV_A;
                    end else begin
                        r_state <= S_PUSH;
                    end
                end
                S_DIV_DUR: begin
                    if (i_status.div_done) begin
                        r_state <= S_PUSH;
                    end
                end
                S_DIV_A: begin
                    if (i_status.div_done) begin
                        r_state <= S_DIV_B;
                    end
                end
                S_DIV_B: begin
                    if (i_status.div_done) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ hdl/timed_valve_positioner.sv @@
// Open-loop positioner for a sensorless motorized valve. Each input item is
// one millisecond tick with the commanded opening (0 closed, 255 open); each
// tick gives exactly one result item with the two motor drive lines, the
// estimated position and the mode (idle, opening, closing, cooldown). A tick
// is evaluated once accepted; it then goes straight to a waiting result when
// no estimate is due, through the drive-time division when a drive starts and
// through both position-estimate divisions while the valve moves. The shared
// divider yields two quotient bits per cycle and serves the drive-time and
// both position-estimate divisions one after another. A finished result sits
// in an output register, so the next tick is taken while it waits.
// Configuration writes are accepted in any cycle (ready is tied high) but are
// meant for idle periods; index 0 open travel, 1 close travel, 2 cooldown,
// 3 tolerance.
module timed_valve_positioner
    import tvp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // tick input
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [POS_W-1:0]      i_target_open,

    // result output
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_open_drive,
    output logic                  o_close_drive,
    output logic [POS_W-1:0]      o_position_estimate,
    output logic [1:0]            o_mode_now,

    // register writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    tvp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tvp_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_valid && o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_target_open       (i_target_open),
        .i_cmd               (cmd),
        .o_status            (status),
        .o_open_drive        (o_open_drive),
        .o_close_drive       (o_close_drive),
        .o_position_estimate (o_position_estimate),
        .o_mode_now          (o_mode_now)
    );

    // A new result never lands on one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !(o_valid && !i_ready))
        else $error("result overwritten before it was taken");

    // Once a tick is taken the block is busy with it.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second tick taken while one is in work");

    // Both motor lines never driven together.
    a_drive_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_open_drive && o_close_drive))
        else $error("open and close drive both active");

    // Drive lines follow the reported mode.
    a_drive_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_open_drive == (o_mode_now == MODE_OPENING))
                    && (o_close_drive == (o_mode_now == MODE_CLOSING)))
        else $error("drive lines disagree with mode");

endmodule

@@ verif/tvp_checker.sv @@
module tvp_checker
    import tvp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_tick_valid,
    input  logic                  i_tick_ready,
    input  logic [POS_W-1:0]      i_target_open,

    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic                  i_open_drive,
    input  logic                  i_close_drive,
    input  logic [POS_W-1:0]      i_position_estimate,
    input  logic [1:0]            i_mode_now,

    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    output int                    o_mismatches,
    output int                    o_outstanding,
    output int                    o_compared
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned SCALE = 255;

    typedef struct packed {
        logic             open_drive;
        logic             close_drive;
        logic [POS_W-1:0] position;
        t_mode            mode;
    } t_valve_out;

    // register copies
    logic [TRAV_W-1:0]     open_travel;
    logic [TRAV_W-1:0]     close_travel;
    logic [COOL_W-1:0]     cooldown_len;
    logic [POS_W-1:0]      tolerance;

    // valve state
    t_mode                 mode_q;
    logic [POS_W-1:0]      position_q;
    logic [TIME_WIDTH-1:0] move_time_q;
    logic [TIME_WIDTH-1:0] elapsed_q;
    logic [COOL_W-1:0]     cooldown_left;

    t_valve_out            valve_outputs_due[$];
    int                    mismatches = 0;
    int                    compared   = 0;

    task automatic reset_valve();
        open_travel   = OPEN_TRAVEL_RST;
        close_travel  = CLOSE_TRAVEL_RST;
        cooldown_len  = COOLDOWN_RST;
        tolerance     = TOLERANCE_RST;
        mode_q        = MODE_IDLE;
        position_q    = '0;
        move_time_q   = '0;
        elapsed_q     = '0;
        cooldown_left = '0;
    endtask

    function automatic void start_cooldown();
        cooldown_left = cooldown_len;
        mode_q        = MODE_COOLDOWN;
    endfunction

    // one millisecond tick of the positioner
    function automatic t_valve_out advance_valve(input logic [POS_W-1:0] target);
        int                delta;
        int                tol;
        logic              opening;
        longint unsigned   mag;
        longint unsigned   travel;
        longint unsigned   dur;
        longint unsigned   divisor;
        longint unsigned   a_term;
        longint unsigned   b_term;
        longint unsigned   est;
        t_valve_out        res;

        delta   = int'(target) - int'(position_q);
        tol     = int'(tolerance);
        opening = (mode_q == MODE_OPENING);

        case (mode_q)
            MODE_IDLE: begin
                if (cooldown_left == 0 && (delta > tol || -delta > tol)) begin
                    mag         = (delta > 0) ? delta : -delta;
                    travel      = (delta > 0) ? open_travel : close_travel;
                    dur         = mag * travel / SCALE;
                    move_time_q = (dur > TIME_MAX) ? TIME_MAX : dur[TIME_WIDTH-1:0];
                    elapsed_q   = '0;
                    mode_q      = (delta > 0) ? MODE_OPENING : MODE_CLOSING;
                end
            end
            MODE_OPENING, MODE_CLOSING: begin
                if ((opening && delta <= tol) || (!opening && -delta <= tol)) begin
                    start_cooldown();
                end else begin
                    if (elapsed_q != TIME_MAX)
                        elapsed_q = elapsed_q + 1'b1;
                    if (elapsed_q >= move_time_q) begin
                        position_q = target;
                        start_cooldown();
                    end else begin
                        travel  = opening ? open_travel : close_travel;
                        divisor = (travel == 0) ? 1 : travel;
                        a_term  = elapsed_q * SCALE / divisor;
                        b_term  = move_time_q * SCALE / divisor;
                        est     = opening ? a_term + target - b_term
                                          : target + b_term - a_term;
                        position_q = est[POS_W-1:0];
                    end
                end
            end
            default: begin
                if (cooldown_left != 0)
                    cooldown_left = cooldown_left - 1'b1;
                if (cooldown_left == 0)
                    mode_q = MODE_IDLE;
            end
        endcase

        res.open_drive  = (mode_q == MODE_OPENING);
        res.close_drive = (mode_q == MODE_CLOSING);
        res.position    = position_q;
        res.mode        = mode_q;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_valve_out want;
        if (!i_rst_n) begin
            reset_valve();
            valve_outputs_due.delete();
        end else begin
            // results leave first: a tick taken at this edge cannot be answered yet
            if (i_res_valid && i_res_ready) begin
                if (valve_outputs_due.size() == 0) begin
                    mismatches++;
                    $error("result item with no tick waiting for it");
                end else begin
                    want = valve_outputs_due.pop_front();
                    compared++;
                    if (i_open_drive !== want.open_drive) begin
                        mismatches++;
                        $error("open_drive: expected %0d, got %0d",
                               want.open_drive, i_open_drive);
                    end
                    if (i_close_drive !== want.close_drive) begin
                        mismatches++;
                        $error("close_drive: expected %0d, got %0d",
                               want.close_drive, i_close_drive);
                    end
                    if (i_position_estimate !== want.position) begin
                        mismatches++;
                        $error("position_estimate: expected %0d, got %0d",
                               want.position, i_position_estimate);
                    end
                    if (i_mode_now !== want.mode) begin
                        mismatches++;
                        $error("mode_now: expected %0d, got %0d", want.mode, i_mode_now);
                    end
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_OPEN_TRAVEL:  open_travel  = i_cfg_data[TRAV_W-1:0];
                    REG_CLOSE_TRAVEL: close_travel = i_cfg_data[TRAV_W-1:0];
                    REG_COOLDOWN:     cooldown_len = i_cfg_data[COOL_W-1:0];
                    REG_TOLERANCE:    tolerance    = i_cfg_data[POS_W-1:0];
                    default: ;
                endcase
            end

            if (i_tick_valid && i_tick_ready)
                valve_outputs_due.push_back(advance_valve(i_target_open));
        end

        o_mismatches  <= mismatches;
        o_outstanding <= valve_outputs_due.size();
        o_compared    <= compared;
    end

endmodule

@@ verif/tb_timed_valve_positioner.sv @@
module tb_timed_valve_positioner
    import tvp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Receiver behavior, switched after each random span
    typedef enum {
        STALL_NONE,     // always ready
        STALL_PATTERN,  // rotating fixed bit pattern
        STALL_LIGHT,    // ready about two thirds of the time
        STALL_HEAVY     // ready about one cycle in four
    } t_stall;

    // Fits the slowest legal run many times over
    localparam int RUN_LIMIT_NS = 20_000_000;
    // Margin to let the block settle after the last result
    localparam int SETTLE_CYCLES = 40;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;

    logic                  tick_valid  = 1'b0;
    logic                  tick_ready;
    logic [POS_W-1:0]      tick_target = '0;

    logic                  res_valid;
    logic                  res_ready   = 1'b0;
    logic                  open_drive;
    logic                  close_drive;
    logic [POS_W-1:0]      position_estimate;
    logic [1:0]            mode_now;

    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = REG_OPEN_TRAVEL;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    int                    mismatches;
    int                    outstanding;
    int                    compared;

    int                    ticks_sent  = 0;
    int                    writes_done = 0;
    int                    burst_left  = 0;

    t_stall                stall_style = STALL_NONE;
    int                    stall_span  = 0;
    logic [7:0]            stall_walk  = 8'b1011_0010;

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    timed_valve_positioner DUT (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_valid             (tick_valid),
        .o_ready             (tick_ready),
        .i_target_open       (tick_target),
        .o_valid             (res_valid),
        .i_ready             (res_ready),
        .o_open_drive        (open_drive),
        .o_close_drive       (close_drive),
        .o_position_estimate (position_estimate),
        .o_mode_now          (mode_now),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    // Predicts every tick and checks every result; the top only drives
    tvp_checker u_checker (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_tick_valid        (tick_valid),
        .i_tick_ready        (tick_ready),
        .i_target_open       (tick_target),
        .i_res_valid         (res_valid),
        .i_res_ready         (res_ready),
        .i_open_drive        (open_drive),
        .i_close_drive       (close_drive),
        .i_position_estimate (position_estimate),
        .i_mode_now          (mode_now),
        .i_cfg_valid         (cfg_valid),
        .i_cfg_ready         (cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .o_mismatches        (mismatches),
        .o_outstanding       (outstanding),
        .o_compared          (compared)
    );

    // Result-side backpressure: each style runs for a random span, so stalls
    // land on every stage of the divider sequence, with clean stretches too.
    always @(posedge clk) begin
        if (stall_span == 0) begin
            stall_style <= t_stall'($urandom_range(0, 3));
            stall_span  <= $urandom_range(20, 200);
        end else begin
            stall_span  <= stall_span - 1;
        end
        case (stall_style)
            STALL_NONE:    res_ready <= 1'b1;
            STALL_PATTERN: begin
                res_ready  <= stall_walk[0];
                stall_walk <= {stall_walk[0], stall_walk[7:1]};
            end
            STALL_LIGHT:   res_ready <= ($urandom_range(0, 2) != 0);
            default:       res_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // One tick item. The sender runs in bursts; between bursts valid may drop
    // for a random gap. Valid stays up across back-to-back items in a burst.
    task automatic send_tick(input logic [POS_W-1:0] target);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                tick_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        tick_valid  <= 1'b1;
        tick_target <= target;
        do @(posedge clk); while (!tick_ready);
        burst_left--;
        ticks_sent++;
    endtask

    task automatic hold_target(input logic [POS_W-1:0] target, input int count);
        repeat (count) send_tick(target);
    endtask

    // Stop sending, wait for every predicted result, then let the block settle
    task automatic drain_results();
        tick_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        writes_done++;
    endtask

    // Mostly short travel so drives finish within a held target; now and
    // then zero travel or a wide random value
    function automatic logic [TRAV_W-1:0] random_travel();
        case ($urandom_range(0, 19))
            0, 1:    return '0;
            2:       return TRAV_W'($urandom);
            3, 4, 5: return TRAV_W'($urandom_range(41, 400));
            default: return TRAV_W'($urandom_range(1, 40));
        endcase
    endfunction

    initial begin
        int               run_len;
        int               phase_ticks;
        logic [POS_W-1:0] target;
        logic [POS_W-1:0] tol_pick;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: short travel, small cooldown, zero tolerance ----
        write_register(REG_OPEN_TRAVEL,  CFG_DATA_W'(8));
        write_register(REG_CLOSE_TRAVEL, CFG_DATA_W'(5));
        write_register(REG_COOLDOWN,     CFG_DATA_W'(3));
        write_register(REG_TOLERANCE,    CFG_DATA_W'(0));

        send_tick('0);              // on target: stays idle
        hold_target('1, 4);         // full-open command starts an opening drive
        send_tick('0);              // target drops below estimate mid-drive: stop
        hold_target('0, 3);         // cooldown runs out
        hold_target('0, 6);         // closing drive back to zero
        drain_results();

        // zero open travel, widest close travel, cooldown and tolerance
        // written with junk above their widths
        write_register(REG_OPEN_TRAVEL,  '0);
        write_register(REG_CLOSE_TRAVEL, '1);
        write_register(REG_COOLDOWN,     CFG_DATA_W'(20'hF0000));
        write_register(REG_TOLERANCE,    '1);
        send_tick('1);              // whole range lies inside tolerance
        drain_results();
        write_register(REG_TOLERANCE, CFG_DATA_W'(2));
        hold_target('1, 3);         // zero travel: done on the first drive tick
        hold_target('0, 4);         // full-scale close drive with saturated time
        send_tick('1);              // reversal stops the close drive
        drain_results();

        // ---- random phases: fresh settings, then held targets plus noise ----
        for (int phase = 0; phase < 11; phase++) begin
            write_register(REG_OPEN_TRAVEL,  random_travel());
            write_register(REG_CLOSE_TRAVEL, random_travel());
            write_register(REG_COOLDOWN,
                           {4'($urandom),
                            COOL_W'($urandom_range(0, ($urandom_range(0, 2) == 0) ? 40 : 6))});
            case ($urandom_range(0, 9))
                0:       tol_pick = POS_W'($urandom_range(200, 255));
                1, 2, 3: tol_pick = POS_W'($urandom_range(4, 60));
                default: tol_pick = POS_W'($urandom_range(0, 3));
            endcase
            write_register(REG_TOLERANCE, {12'($urandom), tol_pick});

            phase_ticks = 0;
            while (phase_ticks < 105) begin
                if ($urandom_range(0, 4) != 0) begin
                    // a command held long enough for most drives to finish
                    case ($urandom_range(0, 4))
                        0:       target = '0;
                        1:       target = '1;
                        default: target = POS_W'($urandom);
                    endcase
                    run_len = $urandom_range(1, 50);
                    hold_target(target, run_len);
                end else begin
                    // jittery command: reversals and overshoots mid-drive
                    run_len = $urandom_range(1, 8);
                    repeat (run_len) send_tick(POS_W'($urandom));
                end
                phase_ticks += run_len;
            end
            // the register writes for the next phase also move travel values
            // under a drive that is still running
            drain_results();
        end

        // ---- longest cooldown: once a drive stops, the block sits in
        // cooldown for the rest of the run ----
        write_register(REG_OPEN_TRAVEL,  CFG_DATA_W'(4));
        write_register(REG_CLOSE_TRAVEL, CFG_DATA_W'(4));
        write_register(REG_COOLDOWN,     '1);
        write_register(REG_TOLERANCE,    '0);
        repeat (8) begin
            hold_target('1, 6);
            hold_target('0, 6);
        end
        repeat (30) send_tick(POS_W'($urandom));
        drain_results();

        $display("Summary: %0d ticks with %0d register writes, %0d results compared",
                 ticks_sent, writes_done, compared);
        $display("Summary: zero, short and full-scale travel, tolerance 0 to 255, cooldown 0 to max");
        if (mismatches == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog for a hung handshake
    initial begin
        #RUN_LIMIT_NS;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
